### hw/rtl/ioct_pkg.sv
// Shared operation codes and field widths for the in-order completion epoch tracker.
package ioct_pkg;

  localparam int unsigned OpWidth    = 2;
  localparam int unsigned StampWidth = 63;
  localparam int unsigned SlotWidth  = 6;

  localparam logic [OpWidth-1:0] OP_ENQUEUE  = 2'd0;
  localparam logic [OpWidth-1:0] OP_COMPLETE = 2'd1;
  localparam logic [OpWidth-1:0] OP_QUERY    = 2'd2;

  typedef logic [OpWidth-1:0]    op_t;
  typedef logic [StampWidth-1:0] stamp_t;
  typedef logic [SlotWidth-1:0]  slot_t;

endpackage

### hw/rtl/ioct_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module ioct_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/in_order_completion_epoch_tracker_core.sv
// Top level of the in-order completion epoch tracker: ring control and retire sequencer.
//
//   channel  | handshake            | fields
//   ---------+----------------------+---------------------------------------
//   request  | start high, busy low | operation, timestamp, slot
//   result   | done (one cycle)     | status, assigned_slot, newest_epoch
//
// An enqueue, a complete or an unused operation code shows its result in the
// cycle after the request; a new request is taken in that same cycle. A query
// stays busy while it retires entries, since each retired entry costs one read
// of the ring memories. Reset clears the ring pointers, the occupancy and the
// latest epoch; the memories need no clearing.
// The receiver cannot stall: every result is held for exactly one cycle.
module in_order_completion_epoch_tracker_core #(
  parameter int unsigned RING_DEPTH = 64,
  parameter int unsigned EPOCH_BITS = 63
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  ioct_pkg::op_t       operation,
  input  ioct_pkg::stamp_t    timestamp,
  input  ioct_pkg::slot_t     slot,
  output logic                done,
  output logic                status,
  output ioct_pkg::slot_t     assigned_slot,
  output ioct_pkg::stamp_t    newest_epoch
);

  localparam int unsigned IW = $clog2(RING_DEPTH);
  localparam int unsigned CW = $clog2(RING_DEPTH + 1);
  localparam int unsigned OW = IW + 1;

  localparam logic S_IDLE   = 1'b0;
  localparam logic S_RETIRE = 1'b1;

  logic                  state;
  logic [IW-1:0]         head;
  logic [IW-1:0]         tail;
  logic [CW-1:0]         occ;
  logic [EPOCH_BITS-1:0] retired;

  logic [IW-1:0]         head_adv;
  logic [IW-1:0]         tail_adv;
  logic                  full;
  logic                  accept;
  logic                  enq_ok;
  logic [IW-1:0]         s_idx;
  logic                  s_in_range;
  logic [OW-1:0]         off_raw;
  logic [OW-1:0]         off;
  logic                  cpl_hit;
  logic                  retire_now;

  logic                  epoch_we;
  logic [EPOCH_BITS-1:0] epoch_wdata;
  logic [EPOCH_BITS-1:0] epoch_rdata;
  logic                  flag_we;
  logic [IW-1:0]         flag_waddr;
  logic                  flag_wdata;
  logic                  flag_rdata;
  logic [IW-1:0]         raddr;

  assign busy     = (state != S_IDLE);
  assign accept   = start && !busy;
  assign head_adv = (head == IW'(RING_DEPTH - 1)) ? '0 : head + IW'(1);
  assign tail_adv = (tail == IW'(RING_DEPTH - 1)) ? '0 : tail + IW'(1);
  assign full     = (occ == CW'(RING_DEPTH));
  assign enq_ok   = accept && (operation == ioct_pkg::OP_ENQUEUE) && !full;

  assign s_in_range = ({26'd0, slot} < RING_DEPTH);
  assign s_idx      = IW'(slot);
  assign off_raw    = OW'(s_idx) + OW'(RING_DEPTH) - OW'(head);
  assign off        = (off_raw >= OW'(RING_DEPTH)) ? off_raw - OW'(RING_DEPTH) : off_raw;
  assign cpl_hit    = accept && (operation == ioct_pkg::OP_COMPLETE) && s_in_range
                      && (off < OW'(occ));

  assign retire_now = (state == S_RETIRE) && (occ != '0) && flag_rdata;

  assign raddr       = (state == S_RETIRE) ? head_adv : head;
  assign epoch_we    = enq_ok;
  assign epoch_wdata = EPOCH_BITS'(timestamp);

  always_comb begin
    flag_we    = 1'b0;
    flag_waddr = tail;
    flag_wdata = 1'b0;
    if (enq_ok) begin
      flag_we = 1'b1;
    end else if (cpl_hit) begin
      flag_we    = 1'b1;
      flag_waddr = s_idx;
      flag_wdata = 1'b1;
    end else if (retire_now) begin
      flag_we    = 1'b1;
      flag_waddr = head;
    end
  end

  ioct_ram #(
    .WIDTH (EPOCH_BITS),
    .DEPTH (RING_DEPTH)
  ) u_epoch_ram (
    .clk   (clk),
    .we    (epoch_we),
    .waddr (tail),
    .wdata (epoch_wdata),
    .raddr (raddr),
    .rdata (epoch_rdata)
  );

  ioct_ram #(
    .WIDTH (1),
    .DEPTH (RING_DEPTH)
  ) u_flag_ram (
    .clk   (clk),
    .we    (flag_we),
    .waddr (flag_waddr),
    .wdata (flag_wdata),
    .raddr (raddr),
    .rdata (flag_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      head    <= '0;
      tail    <= '0;
      occ     <= '0;
      retired <= '0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            status        <= 1'b0;
            assigned_slot <= '0;
            newest_epoch  <= '0;
            case (operation)
              ioct_pkg::OP_ENQUEUE: begin
                done <= 1'b1;
                if (full) begin
                  status <= 1'b1;
                end else begin
                  assigned_slot <= ioct_pkg::SlotWidth'(tail);
                  tail          <= tail_adv;
                  occ           <= occ + CW'(1);
                end
              end
              ioct_pkg::OP_QUERY: begin
                state <= S_RETIRE;
              end
              default: begin
                done <= 1'b1;
              end
            endcase
          end
        end
        S_RETIRE: begin
          if (retire_now) begin
            head    <= head_adv;
            occ     <= occ - CW'(1);
            retired <= epoch_rdata;
          end else begin
            state         <= S_IDLE;
            done          <= 1'b1;
            status        <= 1'b0;
            assigned_slot <= '0;
            newest_epoch  <= ioct_pkg::StampWidth'(retired);
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
